// ===== hw/rtl/sdspi_pkg.sv =====
// SD SPI command engine package: engine phase type, result bundle and
// frame/poll constants. No dependencies.
`default_nettype none

package sdspi_pkg;

    localparam int unsigned FRAME_BITS = 48;
    localparam int unsigned BYTE_BITS  = 8;

    localparam logic [7:0] START_PREFIX     = 8'h40;
    localparam logic [7:0] IDLE_BYTE        = 8'hFF;
    localparam logic [3:0] POLL_LIMIT_RESET = 4'd9;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_POLL = 2'd2
    } phase_t;

    typedef struct packed {
        logic       mosi;
        logic       sclk;
        logic       busy;
        logic       done;
        logic [7:0] response;
        logic       no_response;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdspi_engine.sv =====
// SD SPI command engine core: frame shifter, response poller and line levels.
// Updates its state on each accepted request and presents the matching result.
// Depends on sdspi_pkg.
`default_nettype none

module sdspi_engine
    import sdspi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire logic        cmd,
    input  wire logic [5:0]  cmd_index,
    input  wire logic [31:0] argument,
    input  wire logic [6:0]  crc7,
    input  wire logic        miso,
    input  wire logic [3:0]  poll_limit,
    output res_t             res
);

    phase_t      phase_reg, phase_next;
    logic [47:0] frame_reg, frame_next;
    logic [5:0]  bit_cnt_reg, bit_cnt_next;
    logic        high_reg, high_next;
    logic [7:0]  rx_reg, rx_next;
    logic [3:0]  byte_cnt_reg, byte_cnt_next;
    logic        mosi_reg, mosi_next;
    logic        sclk_reg, sclk_next;
    logic [7:0]  resp_reg, resp_next;
    logic        noresp_reg, noresp_next;
    logic        done;

    logic [5:0] bit_cnt_inc;
    logic [3:0] byte_cnt_inc;
    logic [7:0] rx_shifted;

    assign bit_cnt_inc  = bit_cnt_reg + 6'd1;
    assign byte_cnt_inc = byte_cnt_reg + 4'd1;
    assign rx_shifted   = {rx_reg[6:0], miso};

    always_comb begin
        phase_next    = phase_reg;
        frame_next    = frame_reg;
        bit_cnt_next  = bit_cnt_reg;
        high_next     = high_reg;
        rx_next       = rx_reg;
        byte_cnt_next = byte_cnt_reg;
        mosi_next     = mosi_reg;
        sclk_next     = sclk_reg;
        resp_next     = resp_reg;
        noresp_next   = noresp_reg;
        done          = 1'b0;

        if (cmd == CMD_START) begin
            if (phase_reg == PH_IDLE) begin
                frame_next    = {START_PREFIX | {2'b00, cmd_index}, argument, crc7, 1'b1};
                phase_next    = PH_SEND;
                bit_cnt_next  = '0;
                high_next     = 1'b0;
                rx_next       = '0;
                byte_cnt_next = '0;
                resp_next     = '0;
                noresp_next   = 1'b0;
            end
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    sclk_next = 1'b0;
                end
                PH_SEND: begin
                    if (!high_reg) begin
                        mosi_next = frame_reg[FRAME_BITS-1];
                        sclk_next = 1'b0;
                        high_next = 1'b1;
                    end else begin
                        sclk_next    = 1'b1;
                        frame_next   = {frame_reg[FRAME_BITS-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_inc;
                        high_next    = 1'b0;
                        if (bit_cnt_inc >= 6'(FRAME_BITS)) begin
                            phase_next    = PH_POLL;
                            bit_cnt_next  = '0;
                            rx_next       = '0;
                            byte_cnt_next = '0;
                        end
                    end
                end
                PH_POLL: begin
                    mosi_next = 1'b1;
                    if (!high_reg) begin
                        sclk_next = 1'b0;
                        high_next = 1'b1;
                    end else begin
                        sclk_next    = 1'b1;
                        high_next    = 1'b0;
                        rx_next      = rx_shifted;
                        bit_cnt_next = bit_cnt_inc;
                        if (bit_cnt_inc >= 6'(BYTE_BITS)) begin
                            bit_cnt_next  = '0;
                            byte_cnt_next = byte_cnt_inc;
                            resp_next     = rx_shifted;
                            if (rx_shifted != IDLE_BYTE) begin
                                noresp_next = 1'b0;
                                done        = 1'b1;
                            end else if (byte_cnt_inc >= poll_limit) begin
                                noresp_next = 1'b1;
                                done        = 1'b1;
                            end
                            if (done) begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            frame_reg    <= '0;
            bit_cnt_reg  <= '0;
            high_reg     <= 1'b0;
            rx_reg       <= '0;
            byte_cnt_reg <= '0;
            mosi_reg     <= 1'b0;
            sclk_reg     <= 1'b0;
            resp_reg     <= '0;
            noresp_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            frame_reg    <= frame_next;
            bit_cnt_reg  <= bit_cnt_next;
            high_reg     <= high_next;
            rx_reg       <= rx_next;
            byte_cnt_reg <= byte_cnt_next;
            mosi_reg     <= mosi_next;
            sclk_reg     <= sclk_next;
            resp_reg     <= resp_next;
            noresp_reg   <= noresp_next;
        end
    end

    always_comb begin
        res.mosi        = mosi_next;
        res.sclk        = sclk_next;
        res.busy        = (phase_next != PH_IDLE);
        res.done        = done;
        res.response    = resp_next;
        res.no_response = noresp_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sd_spi_command_engine.sv =====
// SD card SPI-mode command engine. A start request loads a 48-bit command frame
// (01 prefix, index, argument, CRC7, stop bit); each tick request is one half SPI
// clock that shifts the frame out MSB first, then polls response bytes until a
// byte other than 0xFF arrives or poll_limit bytes have been read. Every request
// yields exactly one result with the line levels and status after it. The engine
// state updates on acceptance and the result is registered in a single output
// register, presented from the cycle after acceptance, so a new request is taken
// every cycle while m_ready is high; a held result blocks input only while it
// is stalled. cfg_poll_limit is written through its own channel, always ready.
// Depends on sdspi_pkg and sdspi_engine.
`default_nettype none

module sd_spi_command_engine
    import sdspi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_poll_limit,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [5:0]  s_cmd_index,
    input  wire logic [31:0] s_argument,
    input  wire logic [6:0]  s_crc7,
    input  wire logic        s_miso,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_mosi,
    output logic             m_sclk,
    output logic             m_busy_res,
    output logic             m_done_res,
    output logic [7:0]       m_response,
    output logic             m_no_response
);

    logic [3:0] poll_limit_reg;
    logic       m_valid_reg;
    res_t       res_reg;
    res_t       res_next;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg <= POLL_LIMIT_RESET;
        end else if (cfg_valid) begin
            poll_limit_reg <= cfg_poll_limit;
        end
    end

    sdspi_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (accept),
        .cmd        (s_cmd),
        .cmd_index  (s_cmd_index),
        .argument   (s_argument),
        .crc7       (s_crc7),
        .miso       (s_miso),
        .poll_limit (poll_limit_reg),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mosi        = res_reg.mosi;
    assign m_sclk        = res_reg.sclk;
    assign m_busy_res    = res_reg.busy;
    assign m_done_res    = res_reg.done;
    assign m_response    = res_reg.response;
    assign m_no_response = res_reg.no_response;

endmodule

`default_nettype wire

// ===== hw/rtl/sdspi_checker.sv =====
// Port-level checks for the SD SPI command engine result channel.
// Bound to sd_spi_command_engine; no package dependency.
`default_nettype none

module sdspi_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_mosi,
    input wire logic       m_sclk,
    input wire logic       m_busy_res,
    input wire logic       m_done_res,
    input wire logic [7:0] m_response,
    input wire logic       m_no_response
);

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("command finished but still busy");

    a_done_sclk_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_sclk)
        else $error("command finished off the high half");

    a_noresp_idle_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_response |-> m_response == 8'hFF)
        else $error("no response flagged with a real response byte");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mosi) && $stable(m_sclk)
            && $stable(m_busy_res) && $stable(m_done_res) && $stable(m_response)
            && $stable(m_no_response))
        else $error("stalled result changed");

endmodule

bind sd_spi_command_engine sdspi_checker u_sdspi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_mosi        (m_mosi),
    .m_sclk        (m_sclk),
    .m_busy_res    (m_busy_res),
    .m_done_res    (m_done_res),
    .m_response    (m_response),
    .m_no_response (m_no_response)
);

`default_nettype wire
